### hw/rtl/imuc_pkg.sv
package imuc_pkg;

  localparam int BURST_BYTES = 14;
  // bytes 0..12 are kept, the last byte of a burst is used as it arrives
  localparam int STORE_DEPTH = BURST_BYTES - 1;
  localparam int NUM_WORDS   = BURST_BYTES / 2;
  localparam int NUM_AXES    = 6;

  localparam int SUM_W       = 33;
  localparam int FIELD_W     = 25;
  localparam int WORD_W      = 16;
  localparam int Q_FRAC      = 8;
  // |mean| <= 32768, so a Q.8 quotient magnitude stays below 2**24
  localparam int QUOT_W      = 24;
  localparam int DIVISOR_W   = 16;
  localparam int DIVIDEND_W  = 39;
  localparam int DIV_STEPS   = QUOT_W;

  localparam logic [3:0]  LAST_POS     = 4'(BURST_BYTES - 1);
  localparam logic [15:0] TARGET_RESET = 16'd2000;
  localparam logic [FIELD_W-1:0] ONE_G_Q8 = 25'd1048576;

  localparam logic OPC_BYTE  = 1'b0;
  localparam logic OPC_START = 1'b1;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_OFFSETS = 1'b1;

  localparam logic [1:0] CAL_IDLE = 2'd0;
  localparam logic [1:0] CAL_RUN  = 2'd1;
  localparam logic [1:0] CAL_DONE = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

### hw/rtl/imuc_div.sv
module imuc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  imuc_pkg::div_req_t                  req_i,
  input  logic [imuc_pkg::DIVISOR_W-1:0]      divisor_i,
  output imuc_pkg::div_rsp_t                  rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [4:0]                        cnt_q;
  logic [imuc_pkg::DIVISOR_W-1:0]    rem_q;
  logic [imuc_pkg::QUOT_W-1:0]       sh_q;
  logic [imuc_pkg::DIVISOR_W:0]      trial;
  logic                              fits;

  assign trial = {rem_q, sh_q[imuc_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  // restoring divider, one quotient bit per cycle; the quotient shifts in
  // where the low dividend bits shift out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == 5'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(imuc_pkg::DIV_STEPS - 1);
        rem_q  <= {1'b0, req_i.dividend[imuc_pkg::DIVIDEND_W-1:imuc_pkg::QUOT_W]};
        sh_q   <= req_i.dividend[imuc_pkg::QUOT_W-1:0];
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= 16'(trial - {1'b0, divisor_i});
        end else begin
          rem_q <= trial[imuc_pkg::DIVISOR_W-1:0];
        end
        sh_q <= {sh_q[imuc_pkg::QUOT_W-2:0], fits};
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

### hw/rtl/imu_frame_unpack_calibrate.sv
// channel   dir  tdata                                    tuser                     tlast
// s_axis    in   [7:0] data_byte                          [0] opcode, [1] frame_start  -
// m_axis    out  ax, ay, az, temperature, gx, gy, gz,     [0] kind                  last_of_run
//                calibration_status (168 bits)
// cfg       in   cfg_wdata_i: calibration_sample_count    -                         -
//
// bytes 0..12 of a burst and start-calibration items leave the block idle and ready for the next item
// the last byte starts 13 byte store reads, a run check, then the sample load;
// while a run sums it, one read-add-write of the sum memory per axis comes before the load
// a burst that closes a run adds six divider passes (sum read, start, wait) and the offsets load
// no clearing pass after reset: the first sample of a run writes its values into the sums
// both loads wait while the output register is full and m_axis_tready is low
module imu_frame_unpack_calibrate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]    s_axis_tuser,   // [0] opcode, [1] frame_start
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [24:0] accel_x, [49:25] accel_y, [74:50] accel_z, [90:75] temperature,
  // [115:91] gyro_x, [140:116] gyro_y, [165:141] gyro_z, [167:166] calibration_status
  output logic [167:0]  m_axis_tdata,
  output logic          m_axis_tuser,   // [0] kind
  output logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATHER,
    ST_GATHER_END,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_LOAD_SAMPLE,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_LOAD_OFF
  } state_e;

  state_e        state_q;
  logic [3:0]    pos_q;
  logic [3:0]    pos_eff;
  logic [3:0]    rd_cnt_q;
  logic          capt_vld_q;
  logic [3:0]    capt_idx_q;
  logic [15:0]   target_q;
  logic [15:0]   taken_q;
  logic [1:0]    phase_q;
  logic          acc_q;
  logic          offs_q;
  logic          first_q;
  logic [2:0]    acc_idx_q;
  logic [2:0]    div_idx_q;
  logic          neg_q;

  logic          out_vld_q;
  logic [167:0]  out_data_q;
  logic          out_kind_q;
  logic          out_last_q;
  logic          out_free;
  logic          out_load;

  logic          s_acc;
  logic          last_byte;

  // byte store memory
  logic [7:0]    byte_mem [imuc_pkg::STORE_DEPTH];
  logic          byte_we;
  logic [3:0]    byte_waddr;
  logic [3:0]    byte_raddr;
  logic [7:0]    byte_rdata_q;

  // axis sum memory
  logic signed [imuc_pkg::SUM_W-1:0] sum_mem [imuc_pkg::NUM_AXES];
  logic          sum_we;
  logic [2:0]    sum_addr;
  logic signed [imuc_pkg::SUM_W-1:0] sum_wdata;
  logic signed [imuc_pkg::SUM_W-1:0] sum_rdata_q;
  logic [imuc_pkg::SUM_W-1:0]        sum_mag;

  logic [imuc_pkg::WORD_W-1:0]  words_q [imuc_pkg::NUM_WORDS];
  logic [imuc_pkg::WORD_W-1:0]  axis16  [imuc_pkg::NUM_AXES];
  logic [imuc_pkg::WORD_W-1:0]  axis_sel;
  logic [imuc_pkg::FIELD_W-1:0] ax25    [imuc_pkg::NUM_AXES];
  logic [imuc_pkg::FIELD_W-1:0] q_q     [imuc_pkg::NUM_AXES];
  logic [imuc_pkg::FIELD_W-1:0] quot25;

  imuc_pkg::div_req_t div_req;
  imuc_pkg::div_rsp_t div_rsp;

  function automatic logic [167:0] pack_result(
    input logic [24:0] ax, input logic [24:0] ay, input logic [24:0] az,
    input logic [15:0] temp, input logic [24:0] gx, input logic [24:0] gy,
    input logic [24:0] gz, input logic [1:0] status
  );
    return {status, gz, gy, gx, temp, az, ay, ax};
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign pos_eff       = s_axis_tuser[1] ? 4'd0 : pos_q;
  assign last_byte     = (pos_eff == imuc_pkg::LAST_POS);
  assign out_free      = !out_vld_q || m_axis_tready;
  assign out_load      = out_free && (state_q == ST_LOAD_SAMPLE || state_q == ST_LOAD_OFF);

  assign byte_we    = s_acc && (s_axis_tuser[0] == imuc_pkg::OPC_BYTE) && !last_byte;
  assign byte_waddr = pos_eff;
  assign byte_raddr = rd_cnt_q;

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= s_axis_tdata;
    end
    byte_rdata_q <= byte_mem[byte_raddr];
  end

  assign sum_addr  = (state_q == ST_ACC_RD || state_q == ST_ACC_WR) ? acc_idx_q : div_idx_q;
  assign sum_we    = (state_q == ST_ACC_WR);
  // the first sample of a run replaces whatever an earlier run left behind
  assign sum_wdata = (first_q ? 33'sd0 : sum_rdata_q)
                   + $signed({{(imuc_pkg::SUM_W - imuc_pkg::WORD_W){axis_sel[15]}}, axis_sel});

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    sum_rdata_q <= sum_mem[sum_addr];
  end

  always_comb begin
    axis16[0] = 16'd0 - words_q[0];
    axis16[1] = words_q[1];
    axis16[2] = words_q[2];
    axis16[3] = words_q[4];
    axis16[4] = 16'd0 - words_q[5];
    axis16[5] = 16'd0 - words_q[6];
    for (int i = 0; i < imuc_pkg::NUM_AXES; i++) begin
      ax25[i] = {{(imuc_pkg::FIELD_W - imuc_pkg::WORD_W){axis16[i][15]}}, axis16[i]};
    end
  end

  assign axis_sel = axis16[acc_idx_q];

  assign sum_mag          = sum_rdata_q[imuc_pkg::SUM_W-1] ? 33'(-sum_rdata_q) : sum_rdata_q;
  assign div_req.start    = (state_q == ST_DIV_GO);
  assign div_req.dividend = {sum_mag[30:0], {imuc_pkg::Q_FRAC{1'b0}}};

  imuc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (target_q),
    .rsp_o     (div_rsp)
  );

  assign quot25 = {1'b0, div_rsp.quot};

  // payload: words of the burst and offsets in Q.8
  always_ff @(posedge clk_i) begin
    if (s_acc && (s_axis_tuser[0] == imuc_pkg::OPC_BYTE) && last_byte) begin
      words_q[imuc_pkg::NUM_WORDS-1][7:0] <= s_axis_tdata;
    end
    if (capt_vld_q) begin
      if (capt_idx_q[0]) begin
        words_q[capt_idx_q[3:1]][7:0] <= byte_rdata_q;
      end else begin
        words_q[capt_idx_q[3:1]][15:8] <= byte_rdata_q;
      end
    end
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      q_q[div_idx_q] <= neg_q ? 25'd0 - quot25 : quot25;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= '0;
      rd_cnt_q   <= '0;
      capt_vld_q <= 1'b0;
      capt_idx_q <= '0;
      target_q   <= imuc_pkg::TARGET_RESET;
      taken_q    <= '0;
      phase_q    <= imuc_pkg::CAL_IDLE;
      acc_q      <= 1'b0;
      offs_q     <= 1'b0;
      first_q    <= 1'b0;
      acc_idx_q  <= '0;
      div_idx_q  <= '0;
      neg_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_kind_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      capt_vld_q <= (state_q == ST_GATHER);
      capt_idx_q <= rd_cnt_q;

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser[0] == imuc_pkg::OPC_START) begin
              taken_q <= '0;
              phase_q <= imuc_pkg::CAL_RUN;
            end else if (last_byte) begin
              pos_q    <= '0;
              rd_cnt_q <= '0;
              state_q  <= ST_GATHER;
            end else begin
              pos_q <= pos_eff + 4'd1;
            end
          end
        end
        ST_GATHER: begin
          if (rd_cnt_q == 4'(imuc_pkg::STORE_DEPTH - 1)) begin
            state_q <= ST_GATHER_END;
          end else begin
            rd_cnt_q <= rd_cnt_q + 4'd1;
          end
        end
        ST_GATHER_END: begin
          acc_idx_q <= '0;
          if (phase_q == imuc_pkg::CAL_RUN && taken_q < target_q) begin
            acc_q   <= 1'b1;
            first_q <= (taken_q == 16'd0);
            taken_q <= taken_q + 16'd1;
            offs_q  <= (16'(taken_q + 16'd1) == target_q);
            state_q <= ST_ACC_RD;
            if (16'(taken_q + 16'd1) == target_q) begin
              phase_q <= imuc_pkg::CAL_DONE;
            end
          end else begin
            acc_q   <= 1'b0;
            offs_q  <= 1'b0;
            state_q <= ST_LOAD_SAMPLE;
            if (phase_q == imuc_pkg::CAL_RUN) begin
              phase_q <= imuc_pkg::CAL_DONE;
            end
          end
        end
        ST_ACC_RD: begin
          state_q <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          if (acc_idx_q == 3'(imuc_pkg::NUM_AXES - 1)) begin
            state_q <= ST_LOAD_SAMPLE;
          end else begin
            acc_idx_q <= acc_idx_q + 3'd1;
            state_q   <= ST_ACC_RD;
          end
        end
        ST_LOAD_SAMPLE: begin
          if (out_free) begin
            out_kind_q <= imuc_pkg::KIND_SAMPLE;
            out_last_q <= !offs_q;
            out_data_q <= pack_result(ax25[0], ax25[1], ax25[2], words_q[3],
                                      ax25[3], ax25[4], ax25[5], phase_q);
            div_idx_q  <= '0;
            state_q    <= offs_q ? ST_DIV_RD : ST_IDLE;
          end
        end
        ST_DIV_RD: begin
          state_q <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          neg_q   <= sum_rdata_q[imuc_pkg::SUM_W-1];
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (div_idx_q == 3'(imuc_pkg::NUM_AXES - 1)) begin
              state_q <= ST_LOAD_OFF;
            end else begin
              div_idx_q <= div_idx_q + 3'd1;
              state_q   <= ST_DIV_RD;
            end
          end
        end
        ST_LOAD_OFF: begin
          if (out_free) begin
            out_kind_q <= imuc_pkg::KIND_OFFSETS;
            out_last_q <= 1'b1;
            out_data_q <= pack_result(q_q[0], q_q[1], q_q[2] - imuc_pkg::ONE_G_Q8, 16'd0,
                                      q_q[3], q_q[4], q_q[5], phase_q);
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  a_offsets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == imuc_pkg::KIND_OFFSETS) |->
      (out_last_q && out_data_q[167:166] == imuc_pkg::CAL_DONE))
    else $error("offsets transaction without done status or last");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= imuc_pkg::LAST_POS)
    else $error("byte position beyond burst");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_acc_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_we |-> (acc_q && taken_q != 16'd0))
    else $error("sum write outside an accumulating sample");

endmodule

### tb/imu_frame_unpack_calibrate_tb.sv
module imu_frame_unpack_calibrate_tb;

  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS   = 52;

  // receiver stall modes
  localparam int RX_FREE    = 0;
  localparam int RX_PATTERN = 1;
  localparam int RX_RANDOM  = 2;

  typedef struct packed {
    logic                                                     kind;
    logic [imuc_pkg::NUM_AXES-1:0][imuc_pkg::FIELD_W-1:0]     axis;
    logic [imuc_pkg::WORD_W-1:0]                              temperature;
    logic [1:0]                                               status;
    logic                                                     last;
  } imu_result_t;

  class cal_scoreboard;
    imu_result_t pending[$];
    logic [7:0]  burst_bytes [imuc_pkg::STORE_DEPTH];
    logic [3:0]  next_pos;
    longint      axis_sum [imuc_pkg::NUM_AXES];
    logic [15:0] samples_summed;
    logic [15:0] target;
    logic [1:0]  cal_state;
    string       axis_names [imuc_pkg::NUM_AXES];
    int          errors;

    function new();
      next_pos = '0;
      foreach (axis_sum[i]) axis_sum[i] = 0;
      samples_summed = '0;
      target = imuc_pkg::TARGET_RESET;
      cal_state = imuc_pkg::CAL_IDLE;
      errors = 0;
      axis_names = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};
    endfunction

    function void set_target(logic [15:0] value);
      target = value;
    endfunction

    // predicts the sample and offsets transactions caused by one input transaction
    function void note_input(logic opc, logic [7:0] data, logic fs);
      logic [7:0]         full [imuc_pkg::BURST_BYTES];
      logic signed [15:0] word [imuc_pkg::NUM_WORDS];
      longint             axes [imuc_pkg::NUM_AXES];
      longint             quot;
      logic               emit_offsets;
      imu_result_t        r;
      if (opc == imuc_pkg::OPC_START) begin
        foreach (axis_sum[i]) axis_sum[i] = 0;
        samples_summed = '0;
        cal_state = imuc_pkg::CAL_RUN;
        return;
      end
      if (fs) next_pos = '0;
      if (next_pos < imuc_pkg::LAST_POS) begin
        burst_bytes[next_pos] = data;
        next_pos = next_pos + 4'd1;
        return;
      end
      next_pos = '0;
      for (int i = 0; i < imuc_pkg::STORE_DEPTH; i++) full[i] = burst_bytes[i];
      full[imuc_pkg::BURST_BYTES-1] = data;
      for (int i = 0; i < imuc_pkg::NUM_WORDS; i++) word[i] = {full[2*i], full[2*i+1]};
      // 16-bit negation, so -32768 stays as it is
      word[0] = -word[0];
      word[5] = -word[5];
      word[6] = -word[6];
      axes[0] = word[0];
      axes[1] = word[1];
      axes[2] = word[2];
      axes[3] = word[4];
      axes[4] = word[5];
      axes[5] = word[6];

      emit_offsets = 1'b0;
      if (cal_state == imuc_pkg::CAL_RUN) begin
        if (samples_summed >= target) begin
          cal_state = imuc_pkg::CAL_DONE;
        end else begin
          foreach (axis_sum[i]) axis_sum[i] = axis_sum[i] + axes[i];
          samples_summed = samples_summed + 16'd1;
          if (samples_summed == target) begin
            cal_state = imuc_pkg::CAL_DONE;
            emit_offsets = 1'b1;
          end
        end
      end

      r.kind = imuc_pkg::KIND_SAMPLE;
      for (int i = 0; i < imuc_pkg::NUM_AXES; i++) r.axis[i] = axes[i][imuc_pkg::FIELD_W-1:0];
      r.temperature = word[3];
      r.status = cal_state;
      r.last = !emit_offsets;
      pending.push_back(r);
      if (!emit_offsets) return;

      r.kind = imuc_pkg::KIND_OFFSETS;
      for (int i = 0; i < imuc_pkg::NUM_AXES; i++) begin
        // signed division truncates toward zero
        quot = (axis_sum[i] * 256) / longint'(target);
        if (i == 2) quot = quot - longint'(imuc_pkg::ONE_G_Q8);
        r.axis[i] = quot[imuc_pkg::FIELD_W-1:0];
      end
      r.temperature = '0;
      r.status = cal_state;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: kind %0h status %0h", got.kind, got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0h, got %0h", exp.kind, got.kind);
        errors++;
      end
      for (int i = 0; i < imuc_pkg::NUM_AXES; i++) begin
        if (got.axis[i] !== exp.axis[i]) begin
          $error("%s: expected %0h, got %0h", axis_names[i], exp.axis[i], got.axis[i]);
          errors++;
        end
      end
      if (got.temperature !== exp.temperature) begin
        $error("temperature: expected %0h, got %0h", exp.temperature, got.temperature);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("calibration_status: expected %0h, got %0h", exp.status, got.status);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_of_run: expected %0h, got %0h", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;

  cal_scoreboard sb = new();
  imu_result_t   seen;
  int            tx_left = 0;
  bit            tx_steady = 1'b0;
  int            rx_tick = 0;
  int            rx_mode = RX_FREE;

  imu_frame_unpack_calibrate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // receiver backpressure, picking a random stall mode whenever rx_tick is a multiple of 256
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 256 == 0) rx_mode <= $urandom_range(RX_FREE, RX_RANDOM);
    case (rx_mode)
      RX_FREE: m_axis_tready <= 1'b1;
      RX_PATTERN: m_axis_tready <= (rx_tick % 5 != 2) && (rx_tick % 11 < 8);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // both sides are stable at the falling edge, the transaction lands on the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind = m_axis_tuser;
      seen.axis[0] = m_axis_tdata[24:0];
      seen.axis[1] = m_axis_tdata[49:25];
      seen.axis[2] = m_axis_tdata[74:50];
      seen.temperature = m_axis_tdata[90:75];
      seen.axis[3] = m_axis_tdata[115:91];
      seen.axis[4] = m_axis_tdata[140:116];
      seen.axis[5] = m_axis_tdata[165:141];
      seen.status = m_axis_tdata[167:166];
      seen.last = m_axis_tlast;
      sb.check_result(seen);
    end
  end

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'h00;
        1: return 8'h80;
        2: return 8'h7f;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(logic opc, logic [7:0] data, logic fs);
    int gap;
    gap = 0;
    if (tx_left == 0) begin
      tx_left = $urandom_range(1, 24);
      if (!tx_steady) gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= {fs, opc};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    tx_left--;
    sb.note_input(opc, data, fs);
  endtask

  // bytes from..13 of a burst; patterned bursts alternate hi and lo bytes
  task automatic send_burst(bit aligned, bit patterned, logic [7:0] hi, logic [7:0] lo,
                            int from);
    logic [7:0] data;
    logic       fs;
    for (int i = from; i < imuc_pkg::BURST_BYTES; i++) begin
      data = patterned ? ((i % 2 == 0) ? hi : lo) : rand_byte();
      fs = (i == 0) && (aligned || $urandom_range(0, 3) != 0);
      send_item(imuc_pkg::OPC_BYTE, data, fs);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target(logic [15:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_target(value);
  endtask

  task automatic random_phase(int budget);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_burst(1'b0, 1'b0, 8'h00, 8'h00, 0);
        sent += imuc_pkg::BURST_BYTES;
      end else if (pick < 78) begin
        send_item(imuc_pkg::OPC_START, rand_byte(), 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 90) begin
        // burst cut short, the next frame start abandons it
        n = $urandom_range(1, imuc_pkg::STORE_DEPTH);
        for (int i = 0; i < n; i++) send_item(imuc_pkg::OPC_BYTE, rand_byte(), i == 0);
        sent += n;
      end else begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          send_item($urandom_range(0, 9) == 0 ? imuc_pkg::OPC_START : imuc_pkg::OPC_BYTE,
                    rand_byte(), 1'($urandom_range(0, 4) == 0));
        end
        sent += n;
      end
    end
  endtask

  initial begin
    int phase_targets [6];
    phase_targets = '{3, 65535, 2, 6, 1, 4};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start in the middle of a burst keeps the byte position; all words -32768
    tx_steady = 1'b1;
    send_item(imuc_pkg::OPC_BYTE, 8'h80, 1'b1);
    send_item(imuc_pkg::OPC_START, rand_byte(), 1'b1);
    send_burst(1'b1, 1'b1, 8'h80, 8'h00, 1);

    // single-sample runs hit the largest and smallest offsets
    write_target(16'd1);
    send_item(imuc_pkg::OPC_START, rand_byte(), 1'b0);
    send_burst(1'b1, 1'b1, 8'h7f, 8'hff, 0);
    send_item(imuc_pkg::OPC_START, rand_byte(), 1'b1);
    send_burst(1'b1, 1'b1, 8'h80, 8'h00, 0);

    for (int k = 0; k < 6; k++) begin
      write_target(16'(phase_targets[k]));
      // three samples already summed, so this run ends without offsets
      if (phase_targets[k] == 2) send_burst(1'b1, 1'b0, 8'h00, 8'h00, 0);
      tx_steady = ($urandom_range(0, 3) == 0);
      random_phase(PHASE_ITEMS);
      if (phase_targets[k] == 65535) begin
        send_item(imuc_pkg::OPC_START, rand_byte(), 1'b0);
        repeat (3) send_burst(1'b1, 1'b0, 8'h00, 8'h00, 0);
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/imuc_pkg.sv
hw/rtl/imuc_div.sv
hw/rtl/imu_frame_unpack_calibrate.sv
tb/imu_frame_unpack_calibrate_tb.sv
